// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the header parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds at every rising edge outside reset.
`define SHP_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition holds at every rising edge outside reset.
`define SHP_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// File: rtl/shp_pkg.sv
// Types, codes and character constants of the SIP header stream parser.
package shp_pkg;

    // Parse phase of the message.
    typedef enum logic [5:0] {
        PH_FIRST    = 6'b000001,
        PH_SECOND   = 6'b000010,
        PH_THIRD    = 6'b000100,
        PH_PARAMS   = 6'b001000,
        PH_CONTENT  = 6'b010000,
        PH_COMPLETE = 6'b100000
    } phase_t;

    // Progress through the current header slot.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_OPEN  = 4'b0010,
        ST_NAME  = 4'b0100,
        ST_VALUE = 4'b1000
    } slot_stage_t;

    // Progress of the Content-Length number scan.
    typedef enum logic [2:0] {
        NUM_LEAD   = 3'b001,
        NUM_DIGITS = 3'b010,
        NUM_STOP   = 3'b100
    } num_phase_t;

    typedef struct packed {
        logic nl;
        logic space;
        logic word;
    } wait_flags_t;

    typedef struct packed {
        logic third;
        logic second;
        logic first;
    } word_seen_t;

    typedef struct packed {
        phase_t      phase;
        wait_flags_t wait_flags;
        logic        prev_newline;
        word_seen_t  word_seen;
        slot_stage_t slot_stage;
        logic [3:0]  name_match_pos;
        logic        name_is_length;
        logic        value_started;
        num_phase_t  num_phase;
    } shp_ctrl_t;

    typedef struct packed {
        logic [2:0]  byte_role;
        logic        token_start;
        logic        token_end;
        logic [7:0]  out_byte;
        logic [3:0]  slot_index;
        logic        slots_full;
        logic [31:0] body_length;
        logic        header_done;
        logic        message_complete;
    } shp_result_t;

    localparam logic [2:0] ROLE_SKIP  = 3'd0;
    localparam logic [2:0] ROLE_WORD1 = 3'd1;
    localparam logic [2:0] ROLE_WORD2 = 3'd2;
    localparam logic [2:0] ROLE_REST  = 3'd3;
    localparam logic [2:0] ROLE_NAME  = 3'd4;
    localparam logic [2:0] ROLE_VALUE = 3'd5;
    localparam logic [2:0] ROLE_BODY  = 3'd6;
    localparam logic [2:0] ROLE_DONE  = 3'd7;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam logic [3:0] NAME_LEN    = 4'd14;
    localparam logic [3:0] NAME_CLOSED = 4'd15;

    // "content-length" in lower case, entry 0 first; the last two entries pad the table.
    localparam logic [15:0][7:0] LENGTH_NAME = {
        8'h00, 8'h00,
        8'h68, 8'h74, 8'h67, 8'h6E, 8'h65, 8'h6C, 8'h2D,
        8'h74, 8'h6E, 8'h65, 8'h74, 8'h6E, 8'h6F, 8'h63
    };

    localparam shp_ctrl_t CTRL_RESET = '{
        phase:          PH_FIRST,
        wait_flags:     '{nl: 1'b0, space: 1'b0, word: 1'b1},
        prev_newline:   1'b0,
        word_seen:      '{third: 1'b0, second: 1'b0, first: 1'b0},
        slot_stage:     ST_IDLE,
        name_match_pos: 4'd0,
        name_is_length: 1'b1,
        value_started:  1'b0,
        num_phase:      NUM_LEAD
    };

endpackage

// File: rtl/shp_step.sv
// Per-byte next-state and result logic of the SIP header stream parser.
module shp_step
    import shp_pkg::*;
#(
    parameter int MAX_SLOTS   = 16,
    parameter int LENGTH_BITS = 32
)
(
    input  logic [7:0]                         data_byte,
    input  logic                               start_message,
    input  shp_ctrl_t                          ctrl,
    input  logic [$clog2(MAX_SLOTS+1)-1:0]     slot_cnt,
    input  logic [LENGTH_BITS-1:0]             digit_acc,
    input  logic [LENGTH_BITS-1:0]             length,
    input  logic [LENGTH_BITS-1:0]             body_cnt,
    output shp_ctrl_t                          ctrl_next,
    output logic [$clog2(MAX_SLOTS+1)-1:0]     slot_cnt_next,
    output logic [LENGTH_BITS-1:0]             digit_acc_next,
    output logic [LENGTH_BITS-1:0]             length_next,
    output logic [LENGTH_BITS-1:0]             body_cnt_next,
    output shp_result_t                        result
);

    localparam int CNT_W = $clog2(MAX_SLOTS+1);

    shp_ctrl_t              cur;
    logic [CNT_W-1:0]       cnt;
    logic [LENGTH_BITS-1:0] acc;
    logic [LENGTH_BITS-1:0] len;
    logic [LENGTH_BITS-1:0] body;

    wait_flags_t            wf;
    word_seen_t             ws;
    slot_stage_t            st;
    num_phase_t             np;
    logic [3:0]             mpos;
    logic                   nil;
    logic                   vs;
    logic                   hdone;
    logic                   pdone;
    logic                   vskip;
    logic                   dskip;
    logic                   blank;
    logic                   digit;
    logic [7:0]             folded;

    logic [LENGTH_BITS+3:0] acc_x;
    logic [LENGTH_BITS+3:0] acc_mul;
    logic [CNT_W+3:0]       cnt_x;
    logic [LENGTH_BITS+31:0] len_x;

    shp_result_t            res;

    assign blank  = (data_byte == CH_SP) || (data_byte == CH_TAB);
    assign digit  = (data_byte >= CH_0) && (data_byte <= CH_9);
    assign folded = ((data_byte >= CH_UP_A) && (data_byte <= CH_UP_Z)) ?
                    data_byte + CASE_OFS : data_byte;

    // Ten times the accumulator plus the digit; any carry into the top bits saturates.
    assign acc_x   = {4'b0000, acc};
    assign acc_mul = (acc_x << 3) + (acc_x << 1) + {{LENGTH_BITS{1'b0}}, data_byte[3:0]};

    always_comb
    begin
        if (start_message)
        begin
            cur  = CTRL_RESET;
            cnt  = '0;
            acc  = '0;
            len  = '0;
            body = '0;
        end
        else
        begin
            cur  = ctrl;
            cnt  = slot_cnt;
            acc  = digit_acc;
            len  = length;
            body = body_cnt;
        end

        ctrl_next      = cur;
        slot_cnt_next  = cnt;
        digit_acc_next = acc;
        length_next    = len;
        body_cnt_next  = body;

        wf    = cur.wait_flags;
        ws    = cur.word_seen;
        st    = cur.slot_stage;
        np    = cur.num_phase;
        mpos  = cur.name_match_pos;
        nil   = cur.name_is_length;
        vs    = cur.value_started;
        hdone = 1'b0;
        pdone = 1'b0;
        vskip = 1'b0;
        dskip = 1'b0;

        res             = '0;
        res.byte_role   = ROLE_SKIP;
        res.out_byte    = data_byte;

        if (cur.phase == PH_COMPLETE)
        begin
            res.byte_role = ROLE_DONE;
        end
        else if (cur.phase == PH_CONTENT)
        begin
            res.byte_role = ROLE_BODY;
            body_cnt_next = body + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
            if (body_cnt_next >= len)
            begin
                ctrl_next.phase = PH_COMPLETE;
            end
        end
        else
        begin
            if (wf.word)
            begin
                if (blank)
                begin
                    hdone = 1'b1;
                end
                else
                begin
                    wf.word = 1'b0;
                end
            end

            // The rest of the start line runs to its newline.
            if (!hdone && wf.nl)
            begin
                res.byte_role = ROLE_REST;
                if (data_byte == CH_LF)
                begin
                    res.out_byte  = CH_NUL;
                    res.token_end = 1'b1;
                    wf.nl         = 1'b0;
                    wf.space      = 1'b0;
                end
                hdone = 1'b1;
            end

            // A blank line ends the header section.
            if (!hdone && cur.prev_newline && (data_byte == CH_LF))
            begin
                ctrl_next.phase = (len != '0) ? PH_CONTENT : PH_COMPLETE;
                hdone = 1'b1;
            end

            if (!hdone && wf.space)
            begin
                if (blank)
                begin
                    res.out_byte  = CH_NUL;
                    res.token_end = 1'b1;
                    wf.space      = 1'b0;
                end
                else
                begin
                    case (cur.phase)
                        PH_FIRST:  res.byte_role = ROLE_WORD1;
                        PH_SECOND: res.byte_role = ROLE_WORD2;
                        PH_THIRD:  res.byte_role = ROLE_REST;
                        default:   res.byte_role = ROLE_SKIP;
                    endcase
                    hdone = 1'b1;
                end
            end

            if (!hdone)
            begin
                if ((cur.phase == PH_FIRST) || (cur.phase == PH_SECOND))
                begin
                    res.byte_role = (cur.phase == PH_FIRST) ? ROLE_WORD1 : ROLE_WORD2;
                    if (((cur.phase == PH_FIRST) && !ws.first) ||
                        ((cur.phase == PH_SECOND) && !ws.second))
                    begin
                        if (cur.phase == PH_FIRST)
                        begin
                            ws.first = 1'b1;
                        end
                        else
                        begin
                            ws.second = 1'b1;
                        end
                        wf.space        = 1'b1;
                        res.token_start = 1'b1;
                    end
                    else
                    begin
                        ctrl_next.phase = (cur.phase == PH_FIRST) ? PH_SECOND : PH_THIRD;
                        wf.word         = 1'b1;
                    end
                end
                else if (cur.phase == PH_THIRD)
                begin
                    if (!ws.third)
                    begin
                        ws.third        = 1'b1;
                        wf.nl           = 1'b1;
                        ctrl_next.phase = PH_PARAMS;
                        res.byte_role   = ROLE_REST;
                        res.token_start = 1'b1;
                    end
                end
                else
                begin
                    // Header lines.
                    if (st == ST_IDLE)
                    begin
                        if (cnt >= CNT_W'(MAX_SLOTS))
                        begin
                            pdone = 1'b1;
                        end
                        else
                        begin
                            st = ST_OPEN;
                        end
                    end

                    if (!pdone)
                    begin
                        if (st == ST_VALUE)
                        begin
                            res.byte_role  = ROLE_VALUE;
                            res.slot_index = cnt_x[3:0];
                            if (data_byte == CH_LF)
                            begin
                                res.out_byte  = CH_NUL;
                                res.token_end = 1'b1;
                                if (cur.name_is_length)
                                begin
                                    length_next = acc;
                                    st          = ST_OPEN;
                                end
                                else
                                begin
                                    slot_cnt_next = cnt + {{(CNT_W-1){1'b0}}, 1'b1};
                                    st            = ST_IDLE;
                                end
                            end
                            else
                            begin
                                if (!vs)
                                begin
                                    if (blank || (data_byte == CH_CR))
                                    begin
                                        vskip = 1'b1;
                                    end
                                    else
                                    begin
                                        vs              = 1'b1;
                                        res.token_start = 1'b1;
                                    end
                                end
                                if (!vskip)
                                begin
                                    if ((data_byte == CH_TAB) || (data_byte == CH_CR))
                                    begin
                                        res.out_byte = CH_SP;
                                    end
                                    // Decimal scan: white space, optional sign, digits up to the first other byte.
                                    if (np == NUM_LEAD)
                                    begin
                                        if (blank || (data_byte == CH_CR) ||
                                            (data_byte == CH_VT) || (data_byte == CH_FF))
                                        begin
                                            dskip = 1'b1;
                                        end
                                        else if ((data_byte == CH_PLUS) ||
                                                 (data_byte == CH_MINUS))
                                        begin
                                            np    = NUM_DIGITS;
                                            dskip = 1'b1;
                                        end
                                        else
                                        begin
                                            np = digit ? NUM_DIGITS : NUM_STOP;
                                        end
                                    end
                                    else if ((np == NUM_DIGITS) && !digit)
                                    begin
                                        np = NUM_STOP;
                                    end
                                    if (!dskip && (np == NUM_DIGITS) && digit)
                                    begin
                                        digit_acc_next = (acc_mul[LENGTH_BITS+3:LENGTH_BITS] != 4'd0)
                                                         ? {LENGTH_BITS{1'b1}}
                                                         : acc_mul[LENGTH_BITS-1:0];
                                    end
                                end
                            end
                        end
                        else if (st == ST_NAME)
                        begin
                            res.byte_role  = ROLE_NAME;
                            res.slot_index = cnt_x[3:0];
                            if (blank || (data_byte == CH_COLON))
                            begin
                                res.out_byte  = CH_NUL;
                                res.token_end = 1'b1;
                                if (mpos != NAME_CLOSED)
                                begin
                                    if (mpos != NAME_LEN)
                                    begin
                                        nil = 1'b0;
                                    end
                                    mpos = NAME_CLOSED;
                                end
                                if (data_byte == CH_COLON)
                                begin
                                    st             = ST_VALUE;
                                    vs             = 1'b0;
                                    digit_acc_next = '0;
                                    np             = NUM_LEAD;
                                end
                            end
                            else if (mpos != NAME_CLOSED)
                            begin
                                if ((mpos < NAME_LEN) && (folded == LENGTH_NAME[mpos]))
                                begin
                                    mpos = mpos + 4'd1;
                                end
                                else
                                begin
                                    nil = 1'b0;
                                end
                            end
                        end
                        else if (cur.prev_newline && !blank)
                        begin
                            st              = ST_NAME;
                            res.byte_role   = ROLE_NAME;
                            res.token_start = 1'b1;
                            res.slot_index  = cnt_x[3:0];
                            if (folded == LENGTH_NAME[0])
                            begin
                                mpos = 4'd1;
                                nil  = 1'b1;
                            end
                            else
                            begin
                                mpos = 4'd0;
                                nil  = 1'b0;
                            end
                        end
                    end
                end
            end

            ctrl_next.prev_newline = (data_byte == CH_LF) ? 1'b1 :
                                     (data_byte == CH_CR) ? cur.prev_newline : 1'b0;
        end

        ctrl_next.wait_flags     = wf;
        ctrl_next.word_seen      = ws;
        ctrl_next.slot_stage     = st;
        ctrl_next.num_phase      = np;
        ctrl_next.name_match_pos = mpos;
        ctrl_next.name_is_length = nil;
        ctrl_next.value_started  = vs;

        res.slots_full       = (slot_cnt_next >= CNT_W'(MAX_SLOTS));
        res.body_length      = len_x[31:0];
        res.header_done      = (ctrl_next.phase == PH_CONTENT) ||
                               (ctrl_next.phase == PH_COMPLETE);
        res.message_complete = (ctrl_next.phase == PH_COMPLETE);
        result               = res;
    end

    assign cnt_x = {4'b0000, cnt};
    assign len_x = {32'd0, length_next};

endmodule

// File: rtl/sip_header_stream_parser.sv
// SIP header stream parser: one byte in, one tagged byte out, one byte per cycle unless
// out_stall holds the result register; the parse state updates as a byte moves from the
// input register to the result register, so consecutive bytes never wait on each other.
// Reset (rst_n low, asynchronous) empties both registers and puts the parser at the
// start of a message; start_message does the same for the byte that carries it.
module sip_header_stream_parser
    import shp_pkg::*;
#(
    parameter int MAX_SLOTS   = 16,
    parameter int LENGTH_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        start_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  byte_role,
    output logic        token_start,
    output logic        token_end,
    output logic [7:0]  out_byte,
    output logic [3:0]  slot_index,
    output logic        slots_full,
    output logic [31:0] body_length,
    output logic        header_done,
    output logic        message_complete
);

    localparam int CNT_W = $clog2(MAX_SLOTS+1);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [7:0]             in_byte_reg;
    logic                   in_start_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    shp_result_t            result_reg;
    shp_result_t            result_next;

    shp_ctrl_t              ctrl_reg;
    shp_ctrl_t              ctrl_next;
    logic [CNT_W-1:0]       slot_cnt_reg;
    logic [CNT_W-1:0]       slot_cnt_next;
    logic [LENGTH_BITS-1:0] digit_acc_reg;
    logic [LENGTH_BITS-1:0] digit_acc_next;
    logic [LENGTH_BITS-1:0] length_reg;
    logic [LENGTH_BITS-1:0] length_next;
    logic [LENGTH_BITS-1:0] body_cnt_reg;
    logic [LENGTH_BITS-1:0] body_cnt_next;

    logic                   in_take;
    logic                   advance;

    // A byte moves on whenever the result register is empty or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : ((out_valid_reg && !out_stall) ? 1'b0 : out_valid_reg);

    shp_step #(
        .MAX_SLOTS   (MAX_SLOTS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .data_byte      (in_byte_reg),
        .start_message  (in_start_reg),
        .ctrl           (ctrl_reg),
        .slot_cnt       (slot_cnt_reg),
        .digit_acc      (digit_acc_reg),
        .length         (length_reg),
        .body_cnt       (body_cnt_reg),
        .ctrl_next      (ctrl_next),
        .slot_cnt_next  (slot_cnt_next),
        .digit_acc_next (digit_acc_next),
        .length_next    (length_next),
        .body_cnt_next  (body_cnt_next),
        .result         (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_reg      <= CTRL_RESET;
            slot_cnt_reg  <= '0;
            digit_acc_reg <= '0;
            length_reg    <= '0;
            body_cnt_reg  <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                ctrl_reg      <= ctrl_next;
                slot_cnt_reg  <= slot_cnt_next;
                digit_acc_reg <= digit_acc_next;
                length_reg    <= length_next;
                body_cnt_reg  <= body_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg  <= data_byte;
            in_start_reg <= start_message;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign byte_role        = result_reg.byte_role;
    assign token_start      = result_reg.token_start;
    assign token_end        = result_reg.token_end;
    assign out_byte         = result_reg.out_byte;
    assign slot_index       = result_reg.slot_index;
    assign slots_full       = result_reg.slots_full;
    assign body_length      = result_reg.body_length;
    assign header_done      = result_reg.header_done;
    assign message_complete = result_reg.message_complete;

endmodule

// File: rtl/shp_checker.sv
// Port-level checks of the SIP header stream parser and their binding.
`include "assert_macros.svh"

module shp_checker
    import shp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  byte_role,
    input logic        token_end,
    input logic [7:0]  out_byte,
    input logic        header_done,
    input logic        message_complete
);

    // A stalled result transfer keeps its payload.
    `SHP_ASSERT(a_out_hold, clk, rst_n,
        out_valid && out_stall |=> out_valid && $stable(byte_role) &&
        $stable(out_byte) && $stable(token_end), "result changed while stalled")

    // A terminator is always rewritten to NUL.
    `SHP_ASSERT(a_term_nul, clk, rst_n, out_valid && token_end |-> out_byte == 8'h00,
        "terminator not rewritten to NUL")

    // Completion is only reached through the end of the header section.
    `SHP_ASSERT(a_done_hdr, clk, rst_n, out_valid && message_complete |-> header_done,
        "complete without header end")

    // Body bytes only come after the header section.
    `SHP_ASSERT(a_body_hdr, clk, rst_n, out_valid && (byte_role == ROLE_BODY) |-> header_done,
        "body byte before header end")

    // Bytes after completion keep reporting completion.
    `SHP_ASSERT(a_after_done, clk, rst_n,
        out_valid && (byte_role == ROLE_DONE) |-> message_complete,
        "after-complete role without completion")

endmodule

bind sip_header_stream_parser shp_checker u_shp_checker (.*);

// File: verif/shp_tag_checker.sv
// Checker for the SIP header stream parser: predicts each tagged byte and compares it.
`timescale 1ns / 1ps

module shp_tag_checker
    import shp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        start_message,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  byte_role,
    input  logic        token_start,
    input  logic        token_end,
    input  logic [7:0]  out_byte,
    input  logic [3:0]  slot_index,
    input  logic        slots_full,
    input  logic [31:0] body_length,
    input  logic        header_done,
    input  logic        message_complete,
    output int          errors,
    output int          pending
);

    localparam int              MAX_SLOTS = 16;
    localparam longint unsigned LEN_MAX   = 64'hFFFF_FFFF;

    // Parser state as the predictor keeps it.
    phase_t          st_phase;
    wait_flags_t     st_wait;
    logic            st_prev_nl;
    word_seen_t      st_seen;
    int              st_slots;
    slot_stage_t     st_stage;
    logic [3:0]      st_match;
    logic            st_is_len;
    logic            st_val_started;
    num_phase_t      st_num;
    longint unsigned st_accum;
    longint unsigned st_length;
    longint unsigned st_body_cnt;

    shp_result_t tag;
    shp_result_t observed;
    shp_result_t expected_tags[$];
    int          tag_count = 0;

    initial errors = 0;

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at transfer %0d: %s is 0x%0h, expected 0x%0h",
                 tag_count, what, got, want);
        errors++;
    endtask

    task automatic compare_tag(shp_result_t got, shp_result_t want);
        if (got.byte_role !== want.byte_role)
            report("byte_role", 32'(got.byte_role), 32'(want.byte_role));
        if (got.token_start !== want.token_start)
            report("token_start", 32'(got.token_start), 32'(want.token_start));
        if (got.token_end !== want.token_end)
            report("token_end", 32'(got.token_end), 32'(want.token_end));
        if (got.out_byte !== want.out_byte)
            report("out_byte", 32'(got.out_byte), 32'(want.out_byte));
        if (got.slot_index !== want.slot_index)
            report("slot_index", 32'(got.slot_index), 32'(want.slot_index));
        if (got.slots_full !== want.slots_full)
            report("slots_full", 32'(got.slots_full), 32'(want.slots_full));
        if (got.body_length !== want.body_length)
            report("body_length", got.body_length, want.body_length);
        if (got.header_done !== want.header_done)
            report("header_done", 32'(got.header_done), 32'(want.header_done));
        if (got.message_complete !== want.message_complete)
            report("message_complete", 32'(got.message_complete),
                   32'(want.message_complete));
    endtask

    function automatic void reset_parser();
        st_phase       = PH_FIRST;
        st_wait        = '{nl: 1'b0, space: 1'b0, word: 1'b1};
        st_prev_nl     = 1'b0;
        st_seen        = '{third: 1'b0, second: 1'b0, first: 1'b0};
        st_slots       = 0;
        st_stage       = ST_IDLE;
        st_match       = 4'd0;
        st_is_len      = 1'b1;
        st_val_started = 1'b0;
        st_num         = NUM_LEAD;
        st_accum       = 0;
        st_length      = 0;
        st_body_cnt    = 0;
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c == CH_SP || c == CH_TAB;
    endfunction

    function automatic void close_name();
        if (st_match != NAME_CLOSED)
        begin
            if (st_match != NAME_LEN)
                st_is_len = 1'b0;
            st_match = NAME_CLOSED;
        end
    endfunction

    function automatic void match_name(logic [7:0] c);
        logic [7:0] folded;
        if (st_match == NAME_CLOSED)
            return;
        folded = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFS : c;
        if (st_match < NAME_LEN && folded == LENGTH_NAME[st_match])
            st_match++;
        else
            st_is_len = 1'b0;
    endfunction

    // Decimal scan of a Content-Length value: leading white space and one sign are
    // passed over, the first non-digit stops it, and the sum saturates.
    function automatic void push_digit(logic [7:0] c);
        logic            digit;
        longint unsigned d;
        digit = c >= CH_0 && c <= CH_9;
        if (st_num == NUM_LEAD)
        begin
            if (c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF)
                return;
            if (c == CH_PLUS || c == CH_MINUS)
            begin
                st_num = NUM_DIGITS;
                return;
            end
            st_num = digit ? NUM_DIGITS : NUM_STOP;
        end
        else if (st_num == NUM_DIGITS && !digit)
        begin
            st_num = NUM_STOP;
        end
        if (st_num == NUM_DIGITS && digit)
        begin
            d = longint'(c - CH_0);
            if (st_accum > (LEN_MAX - d) / 10)
                st_accum = LEN_MAX;
            else
                st_accum = st_accum * 10 + d;
        end
    endfunction

    function automatic void header_line_byte(logic [7:0] c);
        if (st_stage == ST_IDLE)
        begin
            if (st_slots >= MAX_SLOTS)
                return;
            st_stage = ST_OPEN;
        end
        if (st_stage == ST_VALUE)
        begin
            tag.byte_role  = ROLE_VALUE;
            tag.slot_index = st_slots[3:0];
            if (c == CH_LF)
            begin
                tag.out_byte  = CH_NUL;
                tag.token_end = 1'b1;
                // A length header hands its slot on to the next header.
                if (st_is_len)
                begin
                    st_length = st_accum;
                    st_stage  = ST_OPEN;
                end
                else
                begin
                    st_slots++;
                    st_stage = ST_IDLE;
                end
                return;
            end
            if (!st_val_started)
            begin
                if (is_blank(c) || c == CH_CR)
                    return;
                st_val_started  = 1'b1;
                tag.token_start = 1'b1;
            end
            if (c == CH_TAB || c == CH_CR)
                tag.out_byte = CH_SP;
            push_digit(c);
        end
        else if (st_stage == ST_NAME)
        begin
            tag.byte_role  = ROLE_NAME;
            tag.slot_index = st_slots[3:0];
            if (is_blank(c) || c == CH_COLON)
            begin
                tag.out_byte  = CH_NUL;
                tag.token_end = 1'b1;
                close_name();
                if (c == CH_COLON)
                begin
                    st_stage       = ST_VALUE;
                    st_val_started = 1'b0;
                    st_accum       = 0;
                    st_num         = NUM_LEAD;
                end
            end
            else
            begin
                match_name(c);
            end
        end
        else if (st_prev_nl && !is_blank(c))
        begin
            st_stage        = ST_NAME;
            tag.byte_role   = ROLE_NAME;
            tag.token_start = 1'b1;
            tag.slot_index  = st_slots[3:0];
            st_match        = 4'd0;
            st_is_len       = 1'b1;
            match_name(c);
        end
    endfunction

    function automatic void header_byte(logic [7:0] c);
        logic first;
        if (st_wait.word)
        begin
            if (is_blank(c))
                return;
            st_wait.word = 1'b0;
        end
        if (st_wait.nl)
        begin
            tag.byte_role = ROLE_REST;
            if (c == CH_LF)
            begin
                tag.out_byte  = CH_NUL;
                tag.token_end = 1'b1;
                st_wait.nl    = 1'b0;
                st_wait.space = 1'b0;
            end
            return;
        end
        if (st_prev_nl && c == CH_LF)
        begin
            st_phase = (st_length != 0) ? PH_CONTENT : PH_COMPLETE;
            return;
        end
        if (st_wait.space)
        begin
            if (is_blank(c))
            begin
                tag.out_byte  = CH_NUL;
                tag.token_end = 1'b1;
                st_wait.space = 1'b0;
            end
            else
            begin
                case (st_phase)
                    PH_FIRST:  tag.byte_role = ROLE_WORD1;
                    PH_SECOND: tag.byte_role = ROLE_WORD2;
                    PH_THIRD:  tag.byte_role = ROLE_REST;
                    default:   tag.byte_role = ROLE_SKIP;
                endcase
                return;
            end
        end
        if (st_phase == PH_FIRST || st_phase == PH_SECOND)
        begin
            first         = (st_phase == PH_FIRST);
            tag.byte_role = first ? ROLE_WORD1 : ROLE_WORD2;
            if (first ? !st_seen.first : !st_seen.second)
            begin
                if (first)
                    st_seen.first = 1'b1;
                else
                    st_seen.second = 1'b1;
                st_wait.space   = 1'b1;
                tag.token_start = 1'b1;
            end
            else
            begin
                st_phase     = first ? PH_SECOND : PH_THIRD;
                st_wait.word = 1'b1;
            end
        end
        else if (st_phase == PH_THIRD)
        begin
            if (!st_seen.third)
            begin
                st_seen.third   = 1'b1;
                st_wait.nl      = 1'b1;
                st_phase        = PH_PARAMS;
                tag.byte_role   = ROLE_REST;
                tag.token_start = 1'b1;
            end
        end
        else
        begin
            header_line_byte(c);
        end
    endfunction

    function automatic shp_result_t parse_byte(logic [7:0] c, logic sm);
        if (sm)
            reset_parser();
        tag          = '0;
        tag.out_byte = c;
        if (st_phase == PH_COMPLETE)
        begin
            tag.byte_role = ROLE_DONE;
        end
        else if (st_phase == PH_CONTENT)
        begin
            tag.byte_role = ROLE_BODY;
            st_body_cnt++;
            if (st_body_cnt >= st_length)
                st_phase = PH_COMPLETE;
        end
        else
        begin
            header_byte(c);
            // A CR leaves the newline flag alone, so CR LF CR LF is a blank line.
            if (c == CH_LF)
                st_prev_nl = 1'b1;
            else if (c != CH_CR)
                st_prev_nl = 1'b0;
        end
        tag.slots_full       = st_slots >= MAX_SLOTS;
        tag.body_length      = st_length[31:0];
        tag.header_done      = st_phase == PH_CONTENT || st_phase == PH_COMPLETE;
        tag.message_complete = st_phase == PH_COMPLETE;
        return tag;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_parser();
            expected_tags.delete();
            pending <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_tags.push_back(parse_byte(data_byte, start_message));
            if (out_valid && !out_stall)
            begin
                tag_count++;
                observed = {byte_role, token_start, token_end, out_byte, slot_index,
                            slots_full, body_length, header_done, message_complete};
                if (expected_tags.size() == 0)
                    report("transfer with nothing expected, out_byte", 32'(out_byte), 32'd0);
                else
                    compare_tag(observed, expected_tags.pop_front());
            end
            pending <= expected_tags.size();
        end
    end

endmodule

// File: verif/sip_header_stream_parser_tb.sv
// Testbench top of the SIP header stream parser: clock, reset, message stimulus, verdict.
`timescale 1ns / 1ps

module sip_header_stream_parser_tb;
    import shp_pkg::*;

    localparam int TARGET_BYTES = 1350;

    localparam logic [7:0] SPECIALS [9] = '{CH_SP, CH_TAB, CH_CR, CH_LF, CH_COLON,
                                            CH_PLUS, CH_MINUS, CH_VT, CH_FF};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        start_message;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  byte_role;
    logic        token_start;
    logic        token_end;
    logic [7:0]  out_byte;
    logic [3:0]  slot_index;
    logic        slots_full;
    logic [31:0] body_length;
    logic        header_done;
    logic        message_complete;
    int          errors;
    int          pending;

    logic [7:0]  msg_q[$];
    int          sent = 0;

    sip_header_stream_parser i_dut (.*);

    shp_tag_checker i_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("sip_header_stream_parser test failed");
        $finish;
    end

    // Mostly back to back, sometimes a few cycles, now and then a long pause.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial
    begin
        int run;
        int hold;
        out_stall = 1'b0;
        forever
        begin
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 8);
            repeat (run) @(negedge clk) out_stall <= 1'b0;
            hold = idle_len();
            repeat (hold) @(negedge clk) out_stall <= 1'b1;
        end
    end

    function automatic logic [7:0] name_char();
        logic [7:0] c;
        if ($urandom_range(0, 9) < 7)
        begin
            c = 8'($urandom_range(CH_UP_A, CH_UP_Z));
            if ($urandom_range(0, 1))
                c = c + CASE_OFS;
        end
        else
        begin
            // Any printable or high byte that cannot end a name.
            do
                c = 8'($urandom_range(8'h21, 8'hFF));
            while (c == CH_COLON);
        end
        return c;
    endfunction

    function automatic logic [7:0] value_char();
        logic [7:0] c;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return CH_TAB;
        if (r < 14)
            return CH_CR;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_LF);
        return c;
    endfunction

    function automatic logic [7:0] noise_byte();
        if ($urandom_range(0, 1))
            return SPECIALS[$urandom_range(0, 8)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++)
            msg_q.push_back(s[i]);
    endtask

    task automatic put_blanks(int lo, int hi);
        repeat ($urandom_range(lo, hi))
            msg_q.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
    endtask

    task automatic put_token(int lo, int hi);
        repeat ($urandom_range(lo, hi))
            msg_q.push_back(name_char());
    endtask

    task automatic put_eol();
        int r;
        r = $urandom_range(0, 9);
        if (r == 9)
            msg_q.push_back(CH_CR);
        if (r < 5 || r == 9)
            msg_q.push_back(CH_CR);
        msg_q.push_back(CH_LF);
    endtask

    // Blanks and CRs that a value trims, with the odd VT or FF that starts it.
    task automatic put_value_lead(logic allow_vt_ff);
        repeat ($urandom_range(0, 2))
        begin
            if (allow_vt_ff && $urandom_range(0, 7) == 0)
                msg_q.push_back(SPECIALS[$urandom_range(7, 8)]);
            else
                msg_q.push_back(SPECIALS[$urandom_range(0, 2)]);
        end
    endtask

    task automatic put_header();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            // A line that opens with a blank carries no name.
            put_blanks(1, 2);
            put_token(1, 6);
            put_eol();
        end
        put_token(1, 8);
        if (r >= 5 && r < 10)
        begin
            put_blanks(1, 1);
            put_token(1, 4);
        end
        if (r >= 10 && r < 14)
        begin
            // The name runs on over a line break until the colon arrives.
            put_eol();
            put_token(1, 4);
        end
        msg_q.push_back(CH_COLON);
        put_value_lead(1'b0);
        repeat ($urandom_range(0, 12))
            msg_q.push_back(value_char());
        put_eol();
    endtask

    task automatic put_length_header(int body, logic huge);
        int         r;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        for (int i = 0; i < NAME_LEN; i++)
        begin
            c = LENGTH_NAME[i];
            if (c != CH_MINUS && $urandom_range(0, 1))
                c = c - CASE_OFS;
            if (!(r < 5 && i == NAME_LEN - 1))
                msg_q.push_back(c);
        end
        if (r >= 5 && r < 10)
            msg_q.push_back(name_char());
        if (r >= 10 && r < 20)
            put_blanks(1, 1);
        msg_q.push_back(CH_COLON);
        put_value_lead(1'b1);
        if ($urandom_range(0, 6) == 0)
            msg_q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        if (huge)
        begin
            msg_q.push_back(8'($urandom_range(CH_0 + 1, CH_9)));
            repeat ($urandom_range(9, 14))
                msg_q.push_back(8'($urandom_range(CH_0, CH_9)));
        end
        else
        begin
            put_str($sformatf("%0d", body));
        end
        if ($urandom_range(0, 9) == 0)
            put_token(1, 3);
        put_eol();
    endtask

    task automatic gen_message();
        int   r;
        int   n_hdr;
        int   len_at;
        int   body;
        int   tail;
        logic huge;
        msg_q.delete();
        r      = $urandom_range(0, 99);
        len_at = -1;
        huge   = 1'b0;
        body   = 0;
        if (r < 10)
        begin
            repeat ($urandom_range(5, 40))
                msg_q.push_back(noise_byte());
            return;
        end
        if ($urandom_range(0, 4) == 0)
            put_blanks(1, 2);
        put_token(1, 6);
        if (r >= 16)
        begin
            put_blanks(1, 2);
            put_token(1, 8);
            put_blanks(1, 2);
            put_token(1, 8);
            if ($urandom_range(0, 3) == 0)
            begin
                put_blanks(1, 1);
                put_token(1, 5);
            end
            put_eol();
            n_hdr  = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 5);
            len_at = ($urandom_range(0, 3) == 0) ? -1 : $urandom_range(0, n_hdr);
            huge   = ($urandom_range(0, 24) == 0);
            r      = $urandom_range(0, 99);
            body   = (r < 10) ? 0 : (r < 85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
            for (int k = 0; k <= n_hdr; k++)
            begin
                if (k == len_at)
                    put_length_header(body, huge);
                if (k < n_hdr)
                    put_header();
            end
        end
        else
        begin
            // Start line cut short; the blank line then ends the headers at once.
            put_eol();
        end
        put_eol();
        if (huge)
            tail = $urandom_range(3, 15);
        else if (len_at >= 0)
            tail = body + $urandom_range(0, 3);
        else
            tail = $urandom_range(0, 3);
        repeat (tail)
            msg_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 19) == 0)
            msg_q = msg_q[0:$urandom_range(0, msg_q.size() - 1)];
    endtask

    task automatic send_byte(logic [7:0] b, logic sm, logic steady);
        int gap;
        gap = steady ? 0 : idle_len();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid      <= 1'b0;
            data_byte     <= 8'($urandom);
            start_message <= 1'($urandom);
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        data_byte     <= b;
        start_message <= sm;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_message(logic sm_first);
        logic steady;
        steady = ($urandom_range(0, 4) == 0);
        foreach (msg_q[i])
        begin
            send_byte(msg_q[i], (i == 0) ? sm_first : ($urandom_range(0, 299) == 0), steady);
            sent++;
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = CH_NUL;
        start_message = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Leading blank, all three words, a length header in mixed case with a sign,
        // CR LF CR LF, a two-byte body and a byte after completion.
        msg_q.delete();
        put_str("\tR 1 z\r\nContent-LENGTH: +2\r\n\r\na");
        msg_q.push_back(8'hFF);
        msg_q.push_back(CH_NUL);
        send_message(1'b1);

        while (sent < TARGET_BYTES)
        begin
            gen_message();
            send_message($urandom_range(0, 9) != 0);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (errors == 0)
            $display("sip_header_stream_parser test passed");
        else
            $display("sip_header_stream_parser test failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/shp_pkg.sv
rtl/shp_step.sv
rtl/sip_header_stream_parser.sv
rtl/shp_checker.sv
verif/shp_tag_checker.sv
verif/sip_header_stream_parser_tb.sv
